### hdl/ppp_lcp_link_handshake_top_defines.svh
// Assertion macros used by the PPP LCP handshake top level.
`ifndef PPP_LCP_LINK_HANDSHAKE_TOP_DEFINES_SVH
`define PPP_LCP_LINK_HANDSHAKE_TOP_DEFINES_SVH

// Concurrent check on the rising clock edge, disabled while reset is asserted.
`define PPP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define PPP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ppp_lcp_pkg.sv
// Types and constants for the PPP LCP link handshake.
`timescale 1ns / 1ps
`default_nettype none

package ppp_lcp_pkg;

    localparam int unsigned HEADER_BYTES = 4;

    localparam logic [9:0] MIN_OPEN_FRAME  = 10'(HEADER_BYTES + 4);
    localparam logic [9:0] MIN_OTHER_FRAME = 10'(HEADER_BYTES + 2);

    localparam logic [31:0] MAGIC_STEP     = 32'h1010_2305;
    localparam logic [31:0] MAGIC_RESET    = 32'h153a_7062;
    localparam logic [31:0] ASYNCMAP_RESET = 32'hffff_ffff;
    localparam logic [31:0] OFFERED_RESET  = 32'h000a_0000;
    localparam logic [2:0]  RETRY_RESET    = 3'd3;
    localparam logic [5:0]  OPEN_TO_RESET  = 6'd30;
    localparam logic [5:0]  CLOSE_TO_RESET = 6'd5;

    localparam logic [1:0] CMD_OPEN  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;
    localparam logic [1:0] CMD_CLOSE = 2'd3;

    localparam logic [7:0] CODE_CONFREQ = 8'd1;
    localparam logic [7:0] CODE_CONFACK = 8'd2;
    localparam logic [7:0] CODE_CONFREJ = 8'd4;
    localparam logic [7:0] CODE_TERMREQ = 8'd5;
    localparam logic [7:0] CODE_TERMACK = 8'd6;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_CONFREQ = 3'd1;
    localparam logic [2:0] ACT_CONFACK = 3'd2;
    localparam logic [2:0] ACT_TERMREQ = 3'd3;
    localparam logic [2:0] ACT_TERMACK = 3'd4;

    localparam logic [1:0] OUT_NONE   = 2'd0;
    localparam logic [1:0] OUT_UP     = 2'd1;
    localparam logic [1:0] OUT_FAILED = 2'd2;
    localparam logic [1:0] OUT_CLOSED = 2'd3;

    localparam logic [1:0] REG_ASYNCMAP = 2'd0;
    localparam logic [1:0] REG_RETRY    = 2'd1;
    localparam logic [1:0] REG_OPEN_TO  = 2'd2;
    localparam logic [1:0] REG_CLOSE_TO = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_OPENING = 4'b0010,
        PH_UP      = 4'b0100,
        PH_CLOSING = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  ident;
        logic [31:0] magic;
        logic [15:0] echo;
        logic [1:0]  outcome;
    } t_res;

    typedef struct packed {
        logic        link_up;
        logic [31:0] asyncmap;
        logic        compress;
    } t_stat;

    function automatic t_res make_res(logic [2:0] action, logic [7:0] ident,
                                      logic [31:0] magic, logic [15:0] echo,
                                      logic [1:0] outcome);
        t_res r;
        r.action  = action;
        r.ident   = ident;
        r.magic   = magic;
        r.echo    = echo;
        r.outcome = outcome;
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/ppp_lcp_link_handshake_top.sv
// Top level of the PPP LCP open and close handshake engine.
//
// Commands arrive on the input channel (valid/stall): open, 100 ms tick,
// received LCP packet header or close request. Each transaction yields one or
// two result transactions on the output channel (valid/stall), the final one
// flagged by o_last. Results carry the packet to send, the outcome and the
// link status after the command.
// Configuration registers are written through i_cfg_valid/o_cfg_ready with a
// register index and data; the port is always ready and should be used only
// while no command is in flight.
// From input acceptance to the first result, a command passes one input
// register, then the decision logic into the result register. Without a
// stall, a command that gives one result sustains one transaction per cycle;
// one that gives two results holds the output register until both are taken.
// When the receiver stalls, the result register holds and the input register
// absorbs one more command before o_in_stall rises.
// Synchronous reset restores the default configuration, the idle phase, the
// initial magic number and the all-ones async map, and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

`include "ppp_lcp_link_handshake_top_defines.svh"

module ppp_lcp_link_handshake_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_rx_code,
    input  wire logic [7:0]  i_rx_ident,
    input  wire logic [15:0] i_rx_length,
    input  wire logic [9:0]  i_rx_frame_bytes,
    input  wire logic        i_peer_already_asked,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_action,
    output logic [7:0]       o_packet_ident,
    output logic [31:0]      o_magic_value,
    output logic [15:0]      o_echo_length,
    output logic [1:0]       o_outcome,
    output logic             o_link_is_up,
    output logic [31:0]      o_active_asyncmap,
    output logic             o_compression_on,
    output logic             o_last
);

    logic [31:0] r_offered_asyncmap;
    logic [2:0]  r_retry_limit;
    logic [5:0]  r_open_timeout;
    logic [5:0]  r_close_timeout;

    logic        r_in_valid;
    logic [1:0]  r_command;
    logic [7:0]  r_rx_code;
    logic [7:0]  r_rx_ident;
    logic [15:0] r_rx_length;
    logic [9:0]  r_rx_frame_bytes;
    logic        r_peer_asked;

    ppp_lcp_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_retry_count, n_retry_count;
    logic [5:0]  r_tick_count, n_tick_count;
    logic        r_req_acked, n_req_acked;
    logic        r_peer_seen, n_peer_seen;
    logic [31:0] r_magic, n_magic;
    logic [7:0]  r_ident, n_ident;
    logic [31:0] r_asyncmap, n_asyncmap;
    logic        r_compress, n_compress;

    ppp_lcp_pkg::t_res  r_res [2];
    ppp_lcp_pkg::t_res  n_res [2];
    ppp_lcp_pkg::t_stat r_stat;
    logic [1:0]  r_cnt, n_cnt;

    logic        w_pop;
    logic        w_fire;
    logic        w_in_accept;
    logic [5:0]  w_limit;
    logic        w_done;
    logic        w_last_idx;

    assign w_pop       = o_out_valid && !i_out_stall;
    assign w_fire      = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_pop));
    assign o_in_stall  = r_in_valid && !w_fire;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offered_asyncmap <= ppp_lcp_pkg::OFFERED_RESET;
            r_retry_limit      <= ppp_lcp_pkg::RETRY_RESET;
            r_open_timeout     <= ppp_lcp_pkg::OPEN_TO_RESET;
            r_close_timeout    <= ppp_lcp_pkg::CLOSE_TO_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ppp_lcp_pkg::REG_ASYNCMAP: r_offered_asyncmap <= i_cfg_data;
                ppp_lcp_pkg::REG_RETRY:    r_retry_limit      <= i_cfg_data[2:0];
                ppp_lcp_pkg::REG_OPEN_TO:  r_open_timeout     <= i_cfg_data[5:0];
                ppp_lcp_pkg::REG_CLOSE_TO: r_close_timeout    <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_command        <= i_command;
            r_rx_code        <= i_rx_code;
            r_rx_ident       <= i_rx_ident;
            r_rx_length      <= i_rx_length;
            r_rx_frame_bytes <= i_rx_frame_bytes;
            r_peer_asked     <= i_peer_already_asked;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_retry_count = r_retry_count;
        n_tick_count  = r_tick_count;
        n_req_acked   = r_req_acked;
        n_peer_seen   = r_peer_seen;
        n_magic       = r_magic;
        n_ident       = r_ident;
        n_asyncmap    = r_asyncmap;
        n_compress    = r_compress;
        n_cnt         = 2'd0;
        n_res[0]      = '0;
        n_res[1]      = '0;
        w_done        = 1'b0;
        w_last_idx    = 1'b0;
        w_limit       = (r_phase == ppp_lcp_pkg::PH_OPENING) ? r_open_timeout
                                                              : r_close_timeout;
        case (r_command)
            ppp_lcp_pkg::CMD_OPEN: begin
                if (r_phase == ppp_lcp_pkg::PH_IDLE || r_phase == ppp_lcp_pkg::PH_OPENING) begin
                    n_magic       = r_magic + ppp_lcp_pkg::MAGIC_STEP;
                    n_ident       = r_ident + 8'd1;
                    n_req_acked   = 1'b0;
                    n_peer_seen   = 1'b0;
                    n_retry_count = 3'd0;
                    n_tick_count  = 6'd0;
                    n_phase       = ppp_lcp_pkg::PH_OPENING;
                    n_res[0]      = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_CONFREQ, n_ident,
                                                          n_magic, 16'd0, ppp_lcp_pkg::OUT_NONE);
                    n_cnt         = 2'd1;
                end
            end
            ppp_lcp_pkg::CMD_TICK: begin
                if (r_phase == ppp_lcp_pkg::PH_OPENING || r_phase == ppp_lcp_pkg::PH_CLOSING) begin
                    n_tick_count = r_tick_count + 6'd1;
                    if (n_tick_count >= w_limit) begin
                        n_tick_count  = 6'd0;
                        n_retry_count = r_retry_count + 3'd1;
                        if (n_retry_count >= r_retry_limit) begin
                            n_phase  = ppp_lcp_pkg::PH_IDLE;
                            n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_NONE, 8'd0,
                                32'd0, 16'd0,
                                (r_phase == ppp_lcp_pkg::PH_OPENING) ? ppp_lcp_pkg::OUT_FAILED
                                                                     : ppp_lcp_pkg::OUT_CLOSED);
                            n_cnt    = 2'd1;
                        end else if (!r_req_acked) begin
                            if (r_phase == ppp_lcp_pkg::PH_OPENING) begin
                                n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_CONFREQ,
                                    r_ident, r_magic, 16'd0, ppp_lcp_pkg::OUT_NONE);
                            end else begin
                                n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_TERMREQ,
                                    r_ident, 32'd0, 16'd0, ppp_lcp_pkg::OUT_NONE);
                            end
                            n_cnt = 2'd1;
                        end
                    end
                end
            end
            ppp_lcp_pkg::CMD_RX: begin
                case (r_phase)
                    ppp_lcp_pkg::PH_OPENING: begin
                        if (r_rx_frame_bytes >= ppp_lcp_pkg::MIN_OPEN_FRAME) begin
                            if (r_rx_length > 16'd4) begin
                                if (r_rx_code == ppp_lcp_pkg::CODE_CONFACK) begin
                                    n_req_acked = 1'b1;
                                end else if (r_rx_code == ppp_lcp_pkg::CODE_CONFREQ) begin
                                    n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_CONFACK,
                                        r_rx_ident, 32'd0, r_rx_length - 16'd4,
                                        ppp_lcp_pkg::OUT_NONE);
                                    n_cnt       = 2'd1;
                                    n_peer_seen = 1'b1;
                                end else if (r_rx_code == ppp_lcp_pkg::CODE_CONFREJ) begin
                                    n_phase  = ppp_lcp_pkg::PH_IDLE;
                                    n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_NONE,
                                        8'd0, 32'd0, 16'd0, ppp_lcp_pkg::OUT_FAILED);
                                    n_cnt    = 2'd1;
                                    w_done   = 1'b1;
                                end
                            end else if (r_rx_code == ppp_lcp_pkg::CODE_TERMREQ) begin
                                n_phase  = ppp_lcp_pkg::PH_IDLE;
                                n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_TERMACK,
                                    r_rx_ident, 32'd0, 16'd0, ppp_lcp_pkg::OUT_FAILED);
                                n_cnt    = 2'd1;
                                w_done   = 1'b1;
                            end
                            if (!w_done && n_req_acked && n_peer_seen) begin
                                n_asyncmap = r_offered_asyncmap;
                                n_compress = 1'b1;
                                n_phase    = ppp_lcp_pkg::PH_UP;
                                if (n_cnt != 2'd0) begin
                                    n_res[0].outcome = ppp_lcp_pkg::OUT_UP;
                                end else begin
                                    n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_NONE,
                                        8'd0, 32'd0, 16'd0, ppp_lcp_pkg::OUT_UP);
                                    n_cnt    = 2'd1;
                                end
                            end
                        end
                    end
                    ppp_lcp_pkg::PH_CLOSING: begin
                        if (r_rx_frame_bytes >= ppp_lcp_pkg::MIN_OTHER_FRAME) begin
                            if (r_rx_code == ppp_lcp_pkg::CODE_TERMACK) begin
                                n_req_acked = 1'b1;
                            end else if (r_rx_code == ppp_lcp_pkg::CODE_TERMREQ) begin
                                n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_TERMACK,
                                    r_rx_ident, 32'd0, 16'd0, ppp_lcp_pkg::OUT_NONE);
                                n_cnt       = 2'd1;
                                n_peer_seen = 1'b1;
                            end
                            if (n_req_acked && n_peer_seen) begin
                                n_phase = ppp_lcp_pkg::PH_IDLE;
                                if (n_cnt != 2'd0) begin
                                    n_res[0].outcome = ppp_lcp_pkg::OUT_CLOSED;
                                end else begin
                                    n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_NONE,
                                        8'd0, 32'd0, 16'd0, ppp_lcp_pkg::OUT_CLOSED);
                                    n_cnt    = 2'd1;
                                end
                            end
                        end
                    end
                    ppp_lcp_pkg::PH_UP: begin
                        if (r_rx_frame_bytes >= ppp_lcp_pkg::MIN_OTHER_FRAME &&
                            r_rx_code == ppp_lcp_pkg::CODE_TERMREQ) begin
                            n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_TERMACK,
                                r_rx_ident, 32'd0, 16'd0, ppp_lcp_pkg::OUT_NONE);
                            n_res[1] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_TERMREQ,
                                r_ident, 32'd0, 16'd0, ppp_lcp_pkg::OUT_NONE);
                            n_cnt         = 2'd2;
                            n_req_acked   = 1'b0;
                            n_peer_seen   = 1'b1;
                            n_retry_count = 3'd0;
                            n_tick_count  = 6'd0;
                            n_phase       = ppp_lcp_pkg::PH_CLOSING;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ppp_lcp_pkg::CMD_CLOSE: begin
                if (r_phase == ppp_lcp_pkg::PH_UP) begin
                    n_req_acked   = 1'b0;
                    n_peer_seen   = r_peer_asked;
                    n_retry_count = 3'd0;
                    n_tick_count  = 6'd0;
                    n_phase       = ppp_lcp_pkg::PH_CLOSING;
                    n_res[0]      = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_TERMREQ, r_ident,
                                                          32'd0, 16'd0, ppp_lcp_pkg::OUT_NONE);
                    n_cnt         = 2'd1;
                end
            end
            default: begin
            end
        endcase
        if (n_cnt == 2'd0) begin
            n_res[0] = ppp_lcp_pkg::make_res(ppp_lcp_pkg::ACT_NONE, 8'd0, 32'd0, 16'd0,
                                             ppp_lcp_pkg::OUT_NONE);
            n_cnt    = 2'd1;
        end
        w_last_idx = n_cnt[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ppp_lcp_pkg::PH_IDLE;
            r_retry_count <= 3'd0;
            r_tick_count  <= 6'd0;
            r_req_acked   <= 1'b0;
            r_peer_seen   <= 1'b0;
            r_magic       <= ppp_lcp_pkg::MAGIC_RESET;
            r_ident       <= 8'd0;
            r_asyncmap    <= ppp_lcp_pkg::ASYNCMAP_RESET;
            r_compress    <= 1'b0;
            r_cnt         <= 2'd0;
        end else if (w_fire) begin
            r_phase       <= n_phase;
            r_retry_count <= n_retry_count;
            r_tick_count  <= n_tick_count;
            r_req_acked   <= n_req_acked;
            r_peer_seen   <= n_peer_seen;
            r_magic       <= n_magic;
            r_ident       <= n_ident;
            r_asyncmap    <= n_asyncmap;
            r_compress    <= n_compress;
            r_cnt         <= n_cnt;
        end else if (w_pop) begin
            r_cnt         <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res[0]        <= n_res[0];
            r_res[1]        <= n_res[1];
            r_stat.link_up  <= (n_phase == ppp_lcp_pkg::PH_UP);
            r_stat.asyncmap <= n_asyncmap;
            r_stat.compress <= n_compress;
        end else if (w_pop) begin
            r_res[0]        <= r_res[1];
        end
    end

    assign o_out_valid       = (r_cnt != 2'd0);
    assign o_action          = r_res[0].action;
    assign o_packet_ident    = r_res[0].ident;
    assign o_magic_value     = r_res[0].magic;
    assign o_echo_length     = r_res[0].echo;
    assign o_outcome         = r_res[0].outcome;
    assign o_link_is_up      = r_stat.link_up;
    assign o_active_asyncmap = r_stat.asyncmap;
    assign o_compression_on  = r_stat.compress;
    assign o_last            = (r_cnt == 2'd1);

    `PPP_ASSERT(a_fire_gives_result, i_clk, i_rst_n, w_fire |=> o_out_valid, "Processed transaction produced no result.")
    `PPP_ASSERT(a_two_results_no_outcome, i_clk, i_rst_n, (w_fire && w_last_idx) |-> (n_res[0].outcome == ppp_lcp_pkg::OUT_NONE), "First of two results carries an outcome.")
    `PPP_ASSERT(a_status_matches_phase, i_clk, i_rst_n, w_fire |=> (o_link_is_up == (r_phase == ppp_lcp_pkg::PH_UP)), "Link status disagrees with the phase.")
    `PPP_ASSERT(a_count_bound, i_clk, i_rst_n, r_cnt != 2'd3, "Result register holds more than two results.")
    `PPP_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid, "Result register not empty after reset.")

endmodule

`default_nettype wire
